### src/kmeans_lloyd_iteration_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef KMEANS_LLOYD_ITERATION_MACROS_SVH
`define KMEANS_LLOYD_ITERATION_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define KLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define KLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kli_pkg.sv
`timescale 1ns / 1ps
package kli_pkg;

  localparam int DEF_MAX_CLUSTERS = 8;
  localparam int DEF_MAX_DIMS     = 8;
  localparam int DEF_MAX_POINTS   = 65535;
  localparam int DEF_QUEUE_DEPTH  = 4;

  localparam int FV_W   = 16;
  localparam int DIST_W = 35;
  localparam int SUM_W  = 32;
  localparam int TOT_W  = 51;
  localparam int CNT_W  = 16;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_NUM_DIMS     = 2'd1;
  localparam logic [1:0] REG_TOLERANCE    = 2'd2;

  localparam logic KIND_ASSIGN   = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};

  typedef struct packed {
    logic [1:0]             cmd;
    logic [2:0]             cluster_index;
    logic [2:0]             dim_index;
    logic signed [FV_W-1:0] feature_value;
  } item_t;

  typedef struct packed {
    logic                   kind;
    logic [2:0]             cluster;
    logic [2:0]             dim;
    logic signed [FV_W-1:0] centroid_value;
    logic [DIST_W-1:0]      distance_sq;
    logic [CNT_W-1:0]       cluster_count;
    logic [DIST_W-1:0]      mean_distortion;
    logic                   empty_cluster;
    logic                   changed;
    logic                   last;
  } res_t;

endpackage

### src/kli_fifo.sv
`timescale 1ns / 1ps
module kli_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = kli_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import kli_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W2 = $clog2(DEPTH + 1);

  logic [W-1:0]      slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W2-1:0] count_r;
  logic              push_ok, pop_ok;

  assign full    = (count_r == CNT_W2'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W2'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W2'(1);
      end
    end
  end

endmodule

### src/kli_div.sv
`timescale 1ns / 1ps
module kli_div #(
  parameter int N = 51,
  parameter int M = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  import kli_pkg::*;

  localparam int CW = $clog2(N + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0]  dvd_r;
  logic [M-1:0]  rem_r, dsr_r;
  logic [M:0]    trial, diff;
  logic          ge;

  // restoring division, one quotient bit a cycle
  assign trial    = {rem_r, dvd_r[N-1]};
  assign ge       = (trial >= {1'b0, dsr_r});
  assign diff     = trial - {1'b0, dsr_r};
  assign done     = busy_r && (cnt_r == '0);
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(N);
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        rem_r <= ge ? diff[M-1:0] : trial[M-1:0];
        dvd_r <= {dvd_r[N-2:0], ge};
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

### src/kli_engine.sv
`timescale 1ns / 1ps
module kli_engine #(
  parameter int MAX_CLUSTERS = kli_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = kli_pkg::DEF_MAX_DIMS,
  parameter int MAX_POINTS   = kli_pkg::DEF_MAX_POINTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_valid,
  input  kli_pkg::item_t                     item,
  output logic                               item_pop,
  input  logic [$clog2(MAX_CLUSTERS+1)-1:0]  nc,
  input  logic [$clog2(MAX_DIMS+1)-1:0]      nd,
  input  logic [kli_pkg::DIST_W-1:0]         tol,
  output logic                               res_push,
  output kli_pkg::res_t                      res,
  input  logic                               res_full
);
  import kli_pkg::*;

  localparam int KW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int KCW = $clog2(MAX_CLUSTERS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int ENT = MAX_CLUSTERS * MAX_DIMS;
  localparam int AW  = (ENT > 1) ? $clog2(ENT) : 1;
  localparam int PW  = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRD   = 4'd1;
  localparam logic [3:0] S_DMUL  = 4'd2;
  localparam logic [3:0] S_DACC  = 4'd3;
  localparam logic [3:0] S_ARD   = 4'd4;
  localparam logic [3:0] S_AWR   = 4'd5;
  localparam logic [3:0] S_AEMIT = 4'd6;
  localparam logic [3:0] S_MDIV  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FLAT  = 4'd9;
  localparam logic [3:0] S_FDIV  = 4'd10;
  localparam logic [3:0] S_FMUL  = 4'd11;
  localparam logic [3:0] S_FACC  = 4'd12;
  localparam logic [3:0] S_FEMIT = 4'd13;

  logic [3:0] st_r;
  logic [KW-1:0] k_r, best_r, k_sel;
  logic [DW-1:0] d_r;
  logic [DIST_W-1:0] acc_r, bestd_r, move_r, mean_r;
  logic [31:0] sq_r;
  logic chg_r, neg_r;
  logic signed [FV_W-1:0] old_r, fresh_r;
  logic signed [FV_W-1:0] pb_r [MAX_DIMS];
  logic [PW-1:0] cnt_r [MAX_CLUSTERS];
  logic [TOT_W-1:0] tot_r;
  logic [PW-1:0] pts_r;

  // centroid store and sum memory
  logic signed [FV_W-1:0]  cst_mem [ENT];
  logic signed [SUM_W-1:0] sum_mem [ENT];
  logic signed [FV_W-1:0]  cst_q, cst_wd;
  logic signed [SUM_W-1:0] sum_q, sum_wd;
  logic [AW-1:0] addr_cur, load_addr, cst_wa;
  logic cst_we, sum_we;

  logic d_last, k_last, load_ok, pb_ok, pt_done;
  logic signed [FV_W-1:0] op_a, op_b;
  logic signed [16:0] df;
  logic signed [33:0] prod;
  logic [DIST_W:0] acc_sum;
  logic [DIST_W-1:0] acc_sat, acc_base;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [FV_W-1:0] add_v;
  logic signed [SUM_W:0] s_ext;
  logic [TOT_W:0] tot_sum;
  logic [31:0] sum_mag;
  logic [FV_W-1:0] q_clamp;

  logic div_start, div_done;
  logic [TOT_W-1:0] div_dvd, div_q;
  logic [PW-1:0] div_dsr;

  assign k_sel     = (st_r == S_ARD || st_r == S_AWR) ? best_r : k_r;
  assign addr_cur  = AW'(int'(k_sel) * MAX_DIMS + int'(d_r));
  assign load_addr = AW'(int'(item.cluster_index) * MAX_DIMS + int'(item.dim_index));
  assign d_last    = (DCW'(d_r) + DCW'(1)) == nd;
  assign k_last    = (KCW'(k_r) + KCW'(1)) == nc;
  assign load_ok   = (8'(item.cluster_index) < 8'(MAX_CLUSTERS)) &&
                     (8'(item.dim_index) < 8'(MAX_DIMS));
  assign pb_ok     = 8'(item.dim_index) < 8'(MAX_DIMS);
  assign pt_done   = (8'(item.dim_index) + 8'd1) == 8'(nd);
  assign item_pop  = (st_r == S_IDLE) && item_valid;

  assign cst_we = (item_pop && item.cmd == CMD_LOAD && load_ok) || (st_r == S_FMUL);
  assign cst_wa = (st_r == S_FMUL) ? addr_cur : load_addr;
  assign cst_wd = (st_r == S_FMUL) ? fresh_r : item.feature_value;

  always_ff @(posedge clk) begin
    if (cst_we) begin
      cst_mem[cst_wa] <= cst_wd;
    end
    cst_q <= cst_mem[addr_cur];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[addr_cur] <= sum_wd;
    end
    sum_q <= sum_mem[addr_cur];
  end

  // squared difference: point vs centroid, or new vs old centroid
  assign op_a = (st_r == S_FMUL) ? fresh_r : pb_r[d_r];
  assign op_b = (st_r == S_FMUL) ? old_r : cst_q;
  assign df   = {op_a[FV_W-1], op_a} - {op_b[FV_W-1], op_b};
  assign prod = df * df;

  assign acc_base = (st_r == S_FACC) ? move_r : acc_r;
  assign acc_sum  = {1'b0, acc_base} + (DIST_W+1)'(sq_r);
  assign acc_sat  = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

  // sums of a cluster with no count yet read as zero
  assign sum_base = (cnt_r[best_r] != '0) ? sum_q : '0;
  assign add_v    = (DCW'(d_r) < nd) ? pb_r[d_r] : '0;
  assign s_ext    = {sum_base[SUM_W-1], sum_base} + (SUM_W+1)'(add_v);
  assign sum_we   = (st_r == S_AWR);
  always_comb begin
    if (s_ext[SUM_W] != s_ext[SUM_W-1]) begin
      sum_wd = s_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_wd = s_ext[SUM_W-1:0];
    end
  end

  assign tot_sum = {1'b0, tot_r} + (TOT_W+1)'(bestd_r);
  assign sum_mag = sum_q[SUM_W-1] ? 32'(-sum_q) : 32'(sum_q);

  always_comb begin
    if (!neg_r) begin
      q_clamp = (div_q > TOT_W'(32767)) ? 16'h7FFF : div_q[FV_W-1:0];
    end else begin
      q_clamp = (div_q > TOT_W'(32768)) ? 16'h8000 : (~div_q[FV_W-1:0] + 16'd1);
    end
  end

  assign div_start = (item_pop && item.cmd == CMD_FINISH && pts_r != '0) ||
                     (st_r == S_FLAT && cnt_r[k_r] != '0);
  assign div_dvd   = (st_r == S_FLAT) ? TOT_W'(sum_mag) : tot_r;
  assign div_dsr   = (st_r == S_FLAT) ? cnt_r[k_r] : pts_r;

  kli_div #(.N(TOT_W), .M(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign res_push = (st_r == S_AEMIT || st_r == S_FEMIT) && !res_full;
  always_comb begin
    res = '0;
    if (st_r == S_AEMIT) begin
      res.kind          = KIND_ASSIGN;
      res.cluster       = 3'(best_r);
      res.distance_sq   = bestd_r;
      res.cluster_count = CNT_W'(cnt_r[best_r]);
    end else begin
      res.kind            = KIND_CENTROID;
      res.cluster         = 3'(k_r);
      res.dim             = 3'(d_r);
      res.centroid_value  = fresh_r;
      res.cluster_count   = CNT_W'(cnt_r[k_r]);
      res.mean_distortion = mean_r;
      res.empty_cluster   = (cnt_r[k_r] == '0);
      res.last            = k_last && d_last;
      res.changed         = k_last && d_last && chg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && item.cmd == CMD_POINT && pb_ok) begin
      pb_r[DW'(item.dim_index)] <= item.feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      tot_r <= '0;
      pts_r <= '0;
      chg_r <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      case (st_r)
        S_IDLE: begin
          if (item_pop) begin
            k_r    <= '0;
            d_r    <= '0;
            acc_r  <= '0;
            move_r <= '0;
            chg_r  <= 1'b0;
            if (item.cmd == CMD_POINT && pt_done) begin
              st_r <= S_DRD;
            end else if (item.cmd == CMD_FINISH) begin
              mean_r <= '0;
              st_r   <= (pts_r != '0) ? S_MDIV : S_FRD;
            end
          end
        end
        S_DRD: st_r <= S_DMUL;
        S_DMUL: begin
          sq_r <= prod[31:0];
          st_r <= S_DACC;
        end
        S_DACC: begin
          if (d_last) begin
            if (k_r == '0 || acc_sat < bestd_r) begin
              best_r  <= k_r;
              bestd_r <= acc_sat;
            end
            if (k_last) begin
              d_r  <= '0;
              st_r <= (pts_r < PW'(MAX_POINTS)) ? S_ARD : S_AEMIT;
            end else begin
              k_r   <= k_r + KW'(1);
              d_r   <= '0;
              acc_r <= '0;
              st_r  <= S_DRD;
            end
          end else begin
            d_r   <= d_r + DW'(1);
            acc_r <= acc_sat;
            st_r  <= S_DRD;
          end
        end
        S_ARD: st_r <= S_AWR;
        S_AWR: begin
          // whole row is rewritten so stale dims read back as zero later
          if (d_r == DW'(MAX_DIMS - 1)) begin
            cnt_r[best_r] <= cnt_r[best_r] + PW'(1);
            pts_r <= pts_r + PW'(1);
            tot_r <= tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
            st_r  <= S_AEMIT;
          end else begin
            d_r  <= d_r + DW'(1);
            st_r <= S_ARD;
          end
        end
        S_AEMIT: begin
          if (!res_full) begin
            st_r <= S_IDLE;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean_r <= (div_q > TOT_W'(DIST_MAX)) ? DIST_MAX : div_q[DIST_W-1:0];
            st_r   <= S_FRD;
          end
        end
        S_FRD: st_r <= S_FLAT;
        S_FLAT: begin
          old_r <= cst_q;
          neg_r <= sum_q[SUM_W-1];
          if (cnt_r[k_r] != '0) begin
            st_r <= S_FDIV;
          end else begin
            fresh_r <= cst_q;
            st_r    <= S_FMUL;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            fresh_r <= q_clamp;
            st_r    <= S_FMUL;
          end
        end
        S_FMUL: begin
          sq_r <= prod[31:0];
          st_r <= S_FACC;
        end
        S_FACC: begin
          move_r <= acc_sat;
          if (d_last && acc_sat > tol) begin
            chg_r <= 1'b1;
          end
          st_r <= S_FEMIT;
        end
        S_FEMIT: begin
          if (!res_full) begin
            if (k_last && d_last) begin
              tot_r <= '0;
              pts_r <= '0;
              for (int i = 0; i < MAX_CLUSTERS; i++) begin
                cnt_r[i] <= '0;
              end
              st_r <= S_IDLE;
            end else if (d_last) begin
              k_r    <= k_r + KW'(1);
              d_r    <= '0;
              move_r <= '0;
              st_r   <= S_FRD;
            end else begin
              d_r  <= d_r + DW'(1);
              st_r <= S_FRD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/kmeans_lloyd_iteration.sv
`timescale 1ns / 1ps
// One Lloyd k-means pass on signed Q8.8 features. Items enter a four-deep
// command queue and are executed one at a time by a sequencer behind it;
// results leave through a four-deep result queue. A load item, and a point
// component that does not complete a point, need no further work. A
// completing component has one shared multiplier score each centroid
// component by reading, multiplying and accumulating, then the cluster
// sums are read and written back across MAX_DIMS entries. A finish item
// first divides for the mean distortion if points were taken, then divides
// once per component of a non-empty cluster (an empty one skips the
// divider) on the 51-bit restoring divider, one quotient bit a cycle. The
// centroid store has no reset: read it only after it was loaded.
module kmeans_lloyd_iteration #(
  parameter int MAX_CLUSTERS = kli_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = kli_pkg::DEF_MAX_DIMS,
  parameter int MAX_POINTS   = kli_pkg::DEF_MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        in_cmd,
  input  logic [2:0]                        in_cluster_index,
  input  logic [2:0]                        in_dim_index,
  input  logic signed [kli_pkg::FV_W-1:0]   in_feature_value,
  output logic                              empty,
  input  logic                              pop,
  output logic                              out_kind,
  output logic [2:0]                        out_cluster,
  output logic [2:0]                        out_dim,
  output logic signed [kli_pkg::FV_W-1:0]   out_centroid_value,
  output logic [kli_pkg::DIST_W-1:0]        out_distance_sq,
  output logic [kli_pkg::CNT_W-1:0]         out_cluster_count,
  output logic [kli_pkg::DIST_W-1:0]        out_mean_distortion,
  output logic                              out_empty_cluster,
  output logic                              out_changed,
  output logic                              out_last,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [kli_pkg::DIST_W-1:0]        cfg_data
);
  import kli_pkg::*;

  localparam int KCW = $clog2(MAX_CLUSTERS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int IW  = $bits(item_t);
  localparam int RW  = $bits(res_t);

  logic [3:0]        nclu_r, ndim_r;
  logic [DIST_W-1:0] tol_r;
  logic [7:0]        nc8, nd8;
  logic [KCW-1:0]    nc;
  logic [DCW-1:0]    nd;
  item_t             in_item, q_item;
  res_t              res, res_head;
  logic              q_push, q_empty, item_pop, res_push, res_full;
  logic [IW-1:0]     q_dout;
  logic [RW-1:0]     r_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nclu_r <= 4'd8;
      ndim_r <= 4'd8;
      tol_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_CLUSTERS: nclu_r <= cfg_data[3:0];
        REG_NUM_DIMS:     ndim_r <= cfg_data[3:0];
        REG_TOLERANCE:    tol_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, values above the maximum act as the maximum
  assign nc8 = (nclu_r == 4'd0) ? 8'd1 :
               (8'(nclu_r) > 8'(MAX_CLUSTERS)) ? 8'(MAX_CLUSTERS) : 8'(nclu_r);
  assign nd8 = (ndim_r == 4'd0) ? 8'd1 :
               (8'(ndim_r) > 8'(MAX_DIMS)) ? 8'(MAX_DIMS) : 8'(ndim_r);
  assign nc  = KCW'(nc8);
  assign nd  = DCW'(nd8);

  assign in_item.cmd           = in_cmd;
  assign in_item.cluster_index = in_cluster_index;
  assign in_item.dim_index     = in_dim_index;
  assign in_item.feature_value = in_feature_value;

  // unknown commands are accepted and dropped here
  assign q_push = push && (in_cmd == CMD_LOAD || in_cmd == CMD_POINT || in_cmd == CMD_FINISH);

  kli_fifo #(.W(IW), .DEPTH(DEF_QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (in_item),
    .full  (full),
    .pop   (item_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );
  assign q_item = q_dout;

  kli_engine #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS),
    .MAX_POINTS   (MAX_POINTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_item),
    .item_pop   (item_pop),
    .nc         (nc),
    .nd         (nd),
    .tol        (tol_r),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  kli_fifo #(.W(RW), .DEPTH(DEF_QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (r_dout),
    .empty (empty)
  );
  assign res_head = r_dout;

  assign out_kind            = res_head.kind;
  assign out_cluster         = res_head.cluster;
  assign out_dim             = res_head.dim;
  assign out_centroid_value  = res_head.centroid_value;
  assign out_distance_sq     = res_head.distance_sq;
  assign out_cluster_count   = res_head.cluster_count;
  assign out_mean_distortion = res_head.mean_distortion;
  assign out_empty_cluster   = res_head.empty_cluster;
  assign out_changed         = res_head.changed;
  assign out_last            = res_head.last;

endmodule

### src/kli_checker.sv
`timescale 1ns / 1ps
`include "kmeans_lloyd_iteration_macros.svh"
module kli_assert_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            empty,
  input logic                            pop,
  input logic                            out_kind,
  input logic [2:0]                      out_cluster,
  input logic signed [kli_pkg::FV_W-1:0] out_centroid_value,
  input logic [kli_pkg::CNT_W-1:0]       out_cluster_count,
  input logic                            out_empty_cluster,
  input logic                            out_changed,
  input logic                            out_last
);
  import kli_pkg::*;

  `KLI_ASSERT_NEXT(a_head_holds, !empty && !pop, !empty && $stable(out_centroid_value) && $stable(out_cluster), "result head changed while waiting")
  `KLI_ASSERT_NOW(a_changed_on_last, !empty && out_changed, out_last, "changed flag off the last item")
  `KLI_ASSERT_NOW(a_assign_plain, !empty && out_kind == KIND_ASSIGN, !out_last && !out_empty_cluster && out_centroid_value == '0, "assignment carries finish fields")
  `KLI_ASSERT_NOW(a_empty_count, !empty && out_kind == KIND_CENTROID && out_empty_cluster, out_cluster_count == '0, "empty cluster with nonzero count")

endmodule

bind kmeans_lloyd_iteration kli_assert_chk u_chk (.*);
